@@ rtl/mti_pkg.sv @@
// Package with shared constants for the monotonic table interpolator.
`default_nettype none
package mti_pkg;
  localparam int ENTRY_COUNT_DEF = 64;
  localparam int INDEX_W = 6;
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_FWD = 2'd1;
  localparam logic [1:0] OP_INV = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_MONO = 2'd2;
endpackage
`default_nettype wire

@@ rtl/mti_divider.sv @@
// Restoring serial divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module mti_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [47:0] dividend,
  input  wire logic [39:0] divisor,
  output logic             done,
  output logic [47:0]      quotient
);
  logic [47:0] q_r, q_nxt;
  logic [48:0] rem_r, rem_nxt;
  logic [39:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [48:0] trial;

  // One shift and subtract step per cycle.
  always_comb begin
    trial = {rem_r[47:0], q_r[47]};
    q_nxt = {q_r[46:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {9'd0, den_r}) begin
      rem_nxt = trial - {9'd0, den_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 6'd0;
        q_r <= dividend;
        rem_r <= '0;
        den_r <= divisor;
      end else if (busy_r) begin
        q_r <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quotient = q_r;
endmodule
`default_nettype wire

@@ rtl/monotonic_table_interpolator.sv @@
// Top level of the monotonic table interpolator.
// A forward lookup makes two table reads through the single registered memory port and one
// multiply. An inverse lookup walks the table once through that port to check monotonicity
// and find the bracket, then runs the serial divider. The block accepts one item at a time;
// the result register holds one beat and the next item can be taken while it waits. A result
// that is still stalled when the next one is ready holds the block until it leaves.
`default_nettype none
module monotonic_table_interpolator #(
  parameter int ENTRY_COUNT = mti_pkg::ENTRY_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic signed [8:0]             cfg_min_angle_degrees,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_opcode,
  input  wire logic [mti_pkg::INDEX_W-1:0]   in_entry_index,
  input  wire logic signed [31:0]            in_entry_steps,
  input  wire logic signed [17:0]            in_angle_in,
  input  wire logic signed [31:0]            in_steps_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_status,
  output logic signed [31:0]                 out_result_value
);
  localparam int AW = $clog2(ENTRY_COUNT);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] LAST = CW'(ENTRY_COUNT - 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_WR = 4'd1, S_F0 = 4'd2, S_F1 = 4'd3,
    S_F2 = 4'd4, S_F3 = 4'd5, S_I0 = 4'd6, S_I1 = 4'd7, S_I2 = 4'd8,
    S_IDIV = 4'd9, S_IWAIT = 4'd10, S_DONE = 4'd11;

  logic [3:0] state_r;
  logic signed [31:0] mem [ENTRY_COUNT];
  logic signed [31:0] rd_r;
  logic [AW-1:0] raddr;
  logic signed [8:0] min_r;
  logic [1:0] op_r;
  logic [mti_pkg::INDEX_W-1:0] idx_r;
  logic signed [31:0] wd_r, s_r;
  logic signed [17:0] ang_r;
  logic [CW-1:0] i_r;
  logic [CW-1:0] pi_r;
  logic signed [31:0] prev_r, lo_r, hi_r;
  logic up_r, found_r, mono_bad_r;
  logic [CW-1:0] bi_r;
  logic [1:0] st_r;
  logic signed [31:0] res_r;
  logic signed [19:0] t_r;
  logic signed [42:0] prod_r;
  logic div_start, div_done;
  logic [47:0] div_q;
  logic signed [32:0] d;
  logic signed [19:0] tcalc;
  logic [47:0] num;
  logic [39:0] den;
  logic dir, bad, hit;

  // Table memory with one registered read port.
  always_ff @(posedge clk) begin
    if (state_r == S_WR && 9'(idx_r) < 9'(ENTRY_COUNT))
      mem[AW'(idx_r)] <= wd_r;
    rd_r <= mem[raddr];
  end

  assign raddr = i_r[AW-1:0];
  assign d = 33'(rd_r) - 33'(prev_r);
  assign tcalc = 20'(ang_r) - 20'($signed({min_r, 8'd0}));
  assign in_stall = (state_r != S_IDLE);

  // Inverse walk: the first pair sets the direction and every later pair must agree.
  assign dir = (pi_r == '0) ? (d > 0) : up_r;
  assign bad = (d == 0) || (dir && d < 0) || (!dir && d > 0);
  assign hit = dir ? (s_r >= prev_r && s_r <= rd_r) : (s_r <= prev_r && s_r >= rd_r);

  // Divider operands: magnitude of 256*(s-lo) over magnitude of (hi-lo).
  always_comb begin
    logic signed [33:0] a, b;
    a = 34'(s_r) - 34'(lo_r);
    b = 34'(hi_r) - 34'(lo_r);
    num = 48'(a[33] ? -a : a) << 8;
    den = 40'(b[33] ? -b : b);
  end
  assign div_start = (state_r == S_IDIV);

  mti_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(num),
    .divisor(den), .done(div_done), .quotient(div_q)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      min_r <= '0;
      i_r <= '0;
    end else begin
      if (cfg_we) min_r <= cfg_min_angle_degrees;
      if (out_valid && !out_stall && state_r != S_DONE) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op_r <= in_opcode; idx_r <= in_entry_index; wd_r <= in_entry_steps;
            ang_r <= in_angle_in; s_r <= in_steps_in;
            st_r <= mti_pkg::ST_OK; res_r <= '0;
            i_r <= '0; found_r <= 1'b0; mono_bad_r <= 1'b0;
            case (in_opcode)
              mti_pkg::OP_WRITE: state_r <= S_WR;
              mti_pkg::OP_FWD: state_r <= S_F0;
              mti_pkg::OP_INV: state_r <= S_I0;
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_WR: state_r <= S_DONE;
        S_F0: begin
          t_r <= tcalc;
          if (tcalc < 0 || tcalc > 20'(LAST) * 20'sd256) begin
            st_r <= mti_pkg::ST_RANGE; state_r <= S_DONE;
          end else begin
            i_r <= CW'(tcalc[19:8]); state_r <= S_F1;
          end
        end
        S_F1: begin
          if (i_r != LAST) i_r <= i_r + CW'(1);
          state_r <= S_F2;
        end
        S_F2: begin
          lo_r <= rd_r; state_r <= S_F3; prev_r <= rd_r;
        end
        S_F3: begin
          // rd_r now holds the upper entry (or lower again at the last one).
          prod_r <= 43'($signed({1'b0, t_r[7:0]})) * 43'(d);
          hi_r <= rd_r;
          state_r <= S_IWAIT;
        end
        S_IWAIT: begin
          if (op_r == mti_pkg::OP_FWD) begin
            logic signed [42:0] q;
            q = (prod_r < 0) ? -((-prod_r) >>> 8) : (prod_r >>> 8);
            res_r <= 32'(43'(lo_r) + q);
            state_r <= S_DONE;
          end else if (div_done) begin
            res_r <= 32'($signed({min_r, 8'd0})) + 32'({bi_r, 8'd0}) + 32'(div_q);
            state_r <= S_DONE;
          end
        end
        S_I0: begin
          i_r <= CW'(1); state_r <= S_I1;
        end
        S_I1: begin
          prev_r <= rd_r;
          pi_r <= '0;
          if (i_r != LAST) i_r <= i_r + CW'(1);
          state_r <= S_I2;
        end
        S_I2: begin
          // Walk one pair per cycle: rd_r holds entry pi_r + 1 and prev_r entry pi_r.
          if (pi_r == '0) up_r <= dir;
          if (bad) mono_bad_r <= 1'b1;
          if (!found_r && hit) begin
            found_r <= 1'b1; lo_r <= prev_r; hi_r <= rd_r; bi_r <= pi_r;
          end
          prev_r <= rd_r;
          if (pi_r == LAST - CW'(1)) begin
            if (bad || mono_bad_r) begin
              st_r <= mti_pkg::ST_MONO; state_r <= S_DONE;
            end else if (!found_r && !hit) begin
              st_r <= mti_pkg::ST_RANGE; state_r <= S_DONE;
            end else state_r <= S_IDIV;
          end else begin
            pi_r <= pi_r + CW'(1);
            if (i_r != LAST) i_r <= i_r + CW'(1);
          end
        end
        S_IDIV: state_r <= S_IWAIT;
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_status <= st_r;
            out_result_value <= (st_r == mti_pkg::ST_OK) ? res_r : '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Testbench for the monotonic table interpolator: random and directed lookups checked by a scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  localparam int NUM_ENTRIES = mti_pkg::ENTRY_COUNT_DEF;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] value;
  } lookup_result_t;

  // Scoreboard: keeps its own copy of the table and the angle origin.
  class lookup_scoreboard;
    longint step_table[NUM_ENTRIES];
    longint origin_deg;
    lookup_result_t pending[$];
    int errors;

    function new();
      origin_deg = 0;
      errors = 0;
      foreach (step_table[i]) step_table[i] = 0;
    endfunction

    function void set_origin(logic signed [8:0] deg);
      origin_deg = deg;
    endfunction

    function void note_input(logic [1:0] op, logic [5:0] idx, logic signed [31:0] est,
                             logic signed [17:0] ang, logic signed [31:0] stp);
      lookup_result_t r;
      longint t, lower, frac, lo, hi, s, d, first, last;
      bit up, bad, found;
      r.status = mti_pkg::ST_OK;
      r.value = 0;
      if (op == mti_pkg::OP_WRITE) begin
        if (idx < NUM_ENTRIES) step_table[idx] = est;
      end else if (op == mti_pkg::OP_FWD) begin
        t = longint'(ang) - origin_deg * 256;
        if (t < 0 || t > (NUM_ENTRIES - 1) * 256) begin
          r.status = mti_pkg::ST_RANGE;
        end else begin
          lower = t / 256;
          frac = t - lower * 256;
          lo = step_table[lower];
          if (lower == NUM_ENTRIES - 1) begin
            r.value = 32'(lo);
          end else begin
            hi = step_table[lower + 1];
            r.value = 32'(lo + (frac * (hi - lo)) / 256);
          end
        end
      end else if (op == mti_pkg::OP_INV) begin
        s = stp;
        first = step_table[0];
        last = step_table[NUM_ENTRIES - 1];
        up = step_table[1] > first;
        bad = 0;
        for (int i = 1; i < NUM_ENTRIES; i++) begin
          d = step_table[i] - step_table[i - 1];
          if ((up && d <= 0) || (!up && d >= 0)) bad = 1;
        end
        if (bad) begin
          r.status = mti_pkg::ST_MONO;
        end else if ((up && (s < first || s > last)) || (!up && (s > first || s < last))) begin
          r.status = mti_pkg::ST_RANGE;
        end else begin
          found = 0;
          for (int i = 0; i < NUM_ENTRIES - 1; i++) begin
            lo = step_table[i];
            hi = step_table[i + 1];
            if (!found && ((up && s >= lo && s <= hi) || (!up && s <= lo && s >= hi))) begin
              found = 1;
              r.value = 32'((origin_deg + i) * 256 + ((s - lo) * 256) / (hi - lo));
            end
          end
          if (!found) r.status = mti_pkg::ST_RANGE;
        end
      end
      if (r.status != mti_pkg::ST_OK) r.value = 0;
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic signed [31:0] val);
      lookup_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d value=%0d", $time, st, val);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (val !== e.value) begin
        $display("%0t: value mismatch expected %0d actual %0d", $time, e.value, val);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic signed [8:0] cfg_min_angle_degrees = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_opcode = 0;
  logic [5:0] in_entry_index = 0;
  logic signed [31:0] in_entry_steps = 0;
  logic signed [17:0] in_angle_in = 0;
  logic signed [31:0] in_steps_in = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] out_status;
  logic signed [31:0] out_result_value;

  lookup_scoreboard sb = new();
  bit idle_enable = 1;
  int quiet_cycles = 0;
  // Current shape of the table being built: 0 rising, 1 falling.
  bit table_falls;

  always #5 clk = ~clk;

  monotonic_table_interpolator dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we),
    .cfg_min_angle_degrees(cfg_min_angle_degrees),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_entry_index(in_entry_index), .in_entry_steps(in_entry_steps),
    .in_angle_in(in_angle_in), .in_steps_in(in_steps_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_result_value(out_result_value)
  );

  // Result side: check accepted beats and apply random stalls.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_status, out_result_value);
  end
  always @(negedge clk) begin
    out_stall <= idle_enable && ($urandom_range(99) < 17);
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Valid stays high after an accepted beat; the next beat replaces its fields, and an
  // idle cycle or a drain lowers it at the same falling edge.
  task automatic send_beat(logic [1:0] op, logic [5:0] idx, logic signed [31:0] est,
                           logic signed [17:0] ang, logic signed [31:0] stp);
    while (idle_enable && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_entry_index <= idx;
    in_entry_steps <= est;
    in_angle_in <= ang;
    in_steps_in <= stp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, idx, est, ang, stp);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_origin(logic signed [8:0] deg);
    drain_results();
    cfg_min_angle_degrees <= deg;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_origin(deg);
  endtask

  // Fill the whole table with a strictly monotonic ramp with random slopes.
  task automatic fill_monotonic(int max_step);
    longint v;
    table_falls = 1'($urandom_range(1));
    v = longint'($urandom_range(4000)) - 2000;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      send_beat(mti_pkg::OP_WRITE, i[5:0], v[31:0], '0, '0);
      if (table_falls) v = v - $urandom_range(max_step, 1);
      else v = v + $urandom_range(max_step, 1);
    end
  endtask

  function automatic logic [31:0] rand32();
    return $urandom;
  endfunction

  task automatic random_lookup();
    int k;
    logic signed [17:0] ang;
    longint lo, hi, s;
    k = $urandom_range(99);
    lo = sb.step_table[0];
    hi = sb.step_table[NUM_ENTRIES - 1];
    if (k < 40) begin
      ang = 18'(sb.origin_deg * 256 + longint'($urandom_range((NUM_ENTRIES - 1) * 256)));
      send_beat(mti_pkg::OP_FWD, 6'($urandom), $urandom, ang, $urandom);
    end else if (k < 80) begin
      if (lo > hi) begin s = lo; lo = hi; hi = s; end
      s = lo + longint'($urandom) % (hi - lo + 1);
      if (s < lo) s = s + (hi - lo + 1);
      send_beat(mti_pkg::OP_INV, 6'($urandom), $urandom, 18'($urandom), s[31:0]);
    end else if (k < 88) begin
      send_beat(mti_pkg::OP_FWD, 6'($urandom), $urandom, 18'($urandom), $urandom);
    end else if (k < 94) begin
      send_beat(mti_pkg::OP_INV, 6'($urandom), $urandom, 18'($urandom), rand32());
    end else if (k < 97) begin
      send_beat(mti_pkg::OP_NOP, 6'($urandom), $urandom, 18'($urandom), $urandom);
    end else begin
      // Overwrite an entry with a random value; may break monotonicity.
      send_beat(mti_pkg::OP_WRITE, 6'($urandom), rand32(), 18'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed part: extremes of origin and fields, every opcode.
    write_origin(-9'sd180);
    fill_monotonic(1000);
    send_beat(mti_pkg::OP_FWD, '0, '0, 18'(-46080), '0);
    send_beat(mti_pkg::OP_FWD, '0, '0, 18'(-46080 + 63 * 256), '0);
    send_beat(mti_pkg::OP_FWD, '0, '0, 18'(-46080 + 63 * 256 + 1), '0);
    send_beat(mti_pkg::OP_FWD, '0, '0, 18'(-46081), '0);
    send_beat(mti_pkg::OP_FWD, '0, '0, 18'sh1ffff, '0);
    send_beat(mti_pkg::OP_FWD, '0, '0, 18'sh20000, '0);
    send_beat(mti_pkg::OP_INV, '0, '0, '0, 32'(sb.step_table[0]));
    send_beat(mti_pkg::OP_INV, '0, '0, '0, 32'(sb.step_table[NUM_ENTRIES - 1]));
    send_beat(mti_pkg::OP_INV, '0, '0, '0, 32'sh7fffffff);
    send_beat(mti_pkg::OP_INV, '0, '0, '0, 32'sh80000000);
    send_beat(mti_pkg::OP_NOP, 6'h3f, 32'hffffffff, 18'h3ffff, 32'hffffffff);
    // Equal neighbors on either side of entry 1 break monotonicity.
    send_beat(mti_pkg::OP_WRITE, 6'd1, 32'(sb.step_table[0]), '0, '0);
    send_beat(mti_pkg::OP_INV, '0, '0, '0, '0);
    send_beat(mti_pkg::OP_WRITE, 6'd1, 32'(sb.step_table[2]), '0, '0);
    send_beat(mti_pkg::OP_INV, '0, '0, '0, '0);
    // Full-scale entries at the extremes.
    send_beat(mti_pkg::OP_WRITE, 6'd0, 32'sh80000000, '0, '0);
    send_beat(mti_pkg::OP_WRITE, 6'd1, 32'sh7fffffff, '0, '0);
    send_beat(mti_pkg::OP_FWD, '0, '0, 18'(-46080 + 255), '0);
    write_origin(9'sd180);
    send_beat(mti_pkg::OP_FWD, '0, '0, 18'(46080 + 128), '0);
    send_beat(mti_pkg::OP_FWD, '0, '0, 18'(46079), '0);

    // Random phases with several origin settings.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) idle_enable = 0;
      else idle_enable = 1;
      write_origin(ph == 5 ? 9'sd0 : 9'($signed($urandom_range(360)) - 180));
      fill_monotonic(ph == 3 ? 33000000 : 5000);
      for (int n = 0; n < 250; n++) random_lookup();
      if (ph == 1) drain_results();
    end

    drain_results();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/mti_pkg.sv
rtl/mti_divider.sv
rtl/monotonic_table_interpolator.sv
dv/testbench.sv
